// ===== hw/rtl/pidc_pkg.sv =====
// Shared constants and types for the clamped-integrator PID controller.
// Field widths, register indexes and reset values. No dependencies.
`default_nettype none

package pidc_pkg;

	// default values of the top level parameters
	localparam int SAMPLE_BITS_DEF        = 12;
	localparam int GAIN_FRACTION_BITS_DEF = 24;

	// fixed register and field widths
	localparam int GAIN_W      = 32;
	localparam int LIMIT_W     = 15;
	localparam int SUM_LIMIT_W = 39;
	localparam int ESUM_W      = 40;
	localparam int CAND_W      = ESUM_W + 1;
	localparam int DRIVE_W     = 16;

	// integral product: |sum| split into two partial products
	localparam int MAG_W    = SUM_LIMIT_W;
	localparam int MAG_LO_W = 20;
	localparam int MAG_HI_W = MAG_W - MAG_LO_W;
	localparam int PROD_W   = GAIN_W + MAG_W;
	localparam int I_CAP_LOG = 60;
	localparam int I_W       = I_CAP_LOG + 2;
	localparam int U_W       = 64;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = SUM_LIMIT_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP_GAIN        = 3'd0,
		CFG_KI_GAIN        = 3'd1,
		CFG_KD_GAIN        = 3'd2,
		CFG_INTEGRAL_LIMIT = 3'd3,
		CFG_SUM_LIMIT      = 3'd4,
		CFG_DRIVE_LIMIT    = 3'd5
	} cfg_index_t;

	// register reset values
	localparam logic [GAIN_W-1:0]      KP_GAIN_RST        = 32'd1677722;
	localparam logic [GAIN_W-1:0]      KI_GAIN_RST        = 32'd503;
	localparam logic [GAIN_W-1:0]      KD_GAIN_RST        = 32'd0;
	localparam logic [LIMIT_W-1:0]     INTEGRAL_LIMIT_RST = 15'd1024;
	localparam logic [SUM_LIMIT_W-1:0] SUM_LIMIT_RST      = 39'd34133333;
	localparam logic [LIMIT_W-1:0]     DRIVE_LIMIT_RST    = 15'd1024;

	// master-side payload: drive, drive_saturated, integral_clamped
	localparam int M_TDATA_W = 24;

endpackage : pidc_pkg

`default_nettype wire

// ===== hw/rtl/pid_controller_clamped_integrator_unit.sv =====
// PID controller with clamped integrator, fully pipelined top level.
// Depends on pidc_pkg for widths, register indexes and reset values.
//
// Usage
//   Slave stream s_*: one control sample per transfer, tdata holds target in
//   the low SAMPLE_BITS bits and measured above it, zero padded to bytes.
//   Master stream m_*: one result per sample, tdata holds drive (16-bit two's
//   complement), then drive_saturated, then integral_clamped.
//   cfg_*: plain register write port, one register per index, write only.
//   Registers may only be changed while no sample is in flight.
// Pipeline and throughput
//   A sample accepted into the stage 1 registers moves through the later stage
//   registers in turn and then the output register onto m_tdata. One sample per
//   cycle is taken sustained when nothing stalls: the only loop-carried state is
//   the error sum, whose add/compare/select completes within stage 2. The integral
//   multiply is split into two partial products (stage 3) merged and capped in stage 4.
// Reset and stall
//   arst_n clears all registers of state: gains and limits to their defaults,
//   error sum and previous sample to zero, the pipeline empty.
//   When m_tready is low the result is held; stages behind it keep filling
//   bubbles, so s_tready only drops once every stage holds a sample.
`default_nettype none

module pid_controller_clamped_integrator_unit #(
	parameter int SAMPLE_BITS        = pidc_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRACTION_BITS = pidc_pkg::GAIN_FRACTION_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	// slave stream: [SAMPLE_BITS-1:0] target, [2*SAMPLE_BITS-1:SAMPLE_BITS] measured
	input  wire logic                                    s_tvalid,
	output logic                                         s_tready,
	input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
	// master stream: [15:0] drive, [16] drive_saturated, [17] integral_clamped
	output logic                                         m_tvalid,
	input  wire logic                                    m_tready,
	output logic [pidc_pkg::M_TDATA_W-1:0]               m_tdata,
	// configuration write port
	input  wire logic                                    cfg_we,
	input  wire logic [pidc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [pidc_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import pidc_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int F   = GAIN_FRACTION_BITS;
	localparam int E_W = SB + 1;                 // error and measurement delta
	localparam int P_W = GAIN_W + 1 + E_W;       // signed gain * delta
	localparam logic [PROD_W-1:0] I_CAP = PROD_W'(1) << I_CAP_LOG;
	localparam logic signed [U_W-1:0] FMASK = {{(U_W-F){1'b0}}, {F{1'b1}}};

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [GAIN_W-1:0]      kp_gain_q, ki_gain_q, kd_gain_q;
	logic [LIMIT_W-1:0]     integral_limit_q, drive_limit_q;
	logic [SUM_LIMIT_W-1:0] sum_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_gain_q        <= KP_GAIN_RST;
			ki_gain_q        <= KI_GAIN_RST;
			kd_gain_q        <= KD_GAIN_RST;
			integral_limit_q <= INTEGRAL_LIMIT_RST;
			sum_limit_q      <= SUM_LIMIT_RST;
			drive_limit_q    <= DRIVE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_KP_GAIN:        kp_gain_q        <= cfg_data[GAIN_W-1:0];
				CFG_KI_GAIN:        ki_gain_q        <= cfg_data[GAIN_W-1:0];
				CFG_KD_GAIN:        kd_gain_q        <= cfg_data[GAIN_W-1:0];
				CFG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_SUM_LIMIT:      sum_limit_q      <= cfg_data[SUM_LIMIT_W-1:0];
				CFG_DRIVE_LIMIT:    drive_limit_q    <= cfg_data[LIMIT_W-1:0];
				default: ;  // unmapped index: write dropped
			endcase
		end
	end

	// ---------------------------------------------------------------
	// pipeline control: a stage loads when it is empty or draining
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_out;

	assign en_out   = !out_valid_q || m_tready;
	assign en_s5    = !v_s5 || en_out;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;
	assign m_tvalid = out_valid_q;

	logic in_xfer;
	assign in_xfer = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1        <= s_tvalid;
			if (en_s2)  v_s2        <= v_s1;
			if (en_s3)  v_s3        <= v_s2;
			if (en_s4)  v_s4        <= v_s3;
			if (en_s5)  v_s5        <= v_s4;
			if (en_out) out_valid_q <= v_s5;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: error and measurement delta, previous sample update
	// ---------------------------------------------------------------
	logic [SB-1:0] target, measured, prev_measured_q;
	logic signed [E_W-1:0] err_s1, dmeas_s1;

	assign target   = s_tdata[SB-1:0];
	assign measured = s_tdata[2*SB-1:SB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_measured_q <= '0;
		end else if (in_xfer) begin
			prev_measured_q <= measured;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			err_s1   <= $signed({1'b0, target}) - $signed({1'b0, measured});
			dmeas_s1 <= $signed({1'b0, prev_measured_q}) - $signed({1'b0, measured});
		end
	end

	// ---------------------------------------------------------------
	// stage 2: error sum with bound test, P and D products
	// ---------------------------------------------------------------
	logic signed [ESUM_W-1:0] error_sum_q;
	logic signed [CAND_W-1:0] cand, lim, cand_neg, lim_neg;
	logic                     over, under;

	assign lim      = $signed({{(CAND_W-SUM_LIMIT_W){1'b0}}, sum_limit_q});
	assign lim_neg  = -lim;
	assign cand     = $signed({error_sum_q[ESUM_W-1], error_sum_q})
	                + $signed({{(CAND_W-E_W){err_s1[E_W-1]}}, err_s1});
	assign cand_neg = -cand;
	assign over     = cand > lim;
	assign under    = cand < lim_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
		end else if (en_s2 && v_s1) begin
			if (over)       error_sum_q <= lim[ESUM_W-1:0];
			else if (under) error_sum_q <= lim_neg[ESUM_W-1:0];
			else            error_sum_q <= cand[ESUM_W-1:0];
		end
	end

	logic signed [P_W-1:0] p_s2, d_s2, p_s3, d_s3, p_s4, d_s4;
	logic [MAG_W-1:0]      mag_s2;
	logic                  neg_s2, clamped_s2, neg_s3, clamped_s3, neg_s4, clamped_s4;
	logic                  clamped_s5;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			p_s2       <= $signed({1'b0, kp_gain_q}) * err_s1;
			d_s2       <= $signed({1'b0, kd_gain_q}) * dmeas_s1;
			neg_s2     <= cand[CAND_W-1];
			clamped_s2 <= over || under;
			// only used unclamped, where |cand| <= sum_limit
			mag_s2     <= cand[CAND_W-1] ? cand_neg[MAG_W-1:0] : cand[MAG_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// stage 3: integral partial products
	// ---------------------------------------------------------------
	logic [GAIN_W+MAG_LO_W-1:0] pp_lo_s3;
	logic [GAIN_W+MAG_HI_W-1:0] pp_hi_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			pp_lo_s3   <= ki_gain_q * mag_s2[MAG_LO_W-1:0];
			pp_hi_s3   <= ki_gain_q * mag_s2[MAG_W-1:MAG_LO_W];
			p_s3       <= p_s2;
			d_s3       <= d_s2;
			neg_s3     <= neg_s2;
			clamped_s3 <= clamped_s2;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: merge, cap at 2^60, sign, or pinned integral term
	// ---------------------------------------------------------------
	logic [PROD_W-1:0]       prod, prod_capped;
	logic signed [I_W-1:0]   i_mag, i_pin, i_s4;

	assign prod        = {pp_hi_s3, {MAG_LO_W{1'b0}}}
	                   + {{(PROD_W-GAIN_W-MAG_LO_W){1'b0}}, pp_lo_s3};
	assign prod_capped = (prod > I_CAP) ? I_CAP : prod;
	assign i_mag       = $signed(prod_capped[I_W-1:0]);
	assign i_pin       = $signed({{(I_W-LIMIT_W-F){1'b0}}, integral_limit_q, {F{1'b0}}});

	always_ff @(posedge clk) begin
		if (en_s4) begin
			if (clamped_s3) i_s4 <= neg_s3 ? -i_pin : i_pin;
			else            i_s4 <= neg_s3 ? -i_mag : i_mag;
			p_s4       <= p_s3;
			d_s4       <= d_s3;
			clamped_s4 <= clamped_s3;
		end
	end

	// ---------------------------------------------------------------
	// stage 5: P + I + D
	// ---------------------------------------------------------------
	logic signed [U_W-1:0] u_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			u_s5       <= $signed({{(U_W-P_W){p_s4[P_W-1]}}, p_s4})
			            + $signed({{(U_W-P_W){d_s4[P_W-1]}}, d_s4})
			            + $signed({{(U_W-I_W){i_s4[I_W-1]}}, i_s4});
			clamped_s5 <= clamped_s4;
		end
	end

	// ---------------------------------------------------------------
	// output register: saturate or round toward plus infinity
	// ---------------------------------------------------------------
	logic signed [U_W-1:0]     dlim, u_ceil;
	logic signed [DRIVE_W-1:0] dlim_int;
	logic signed [DRIVE_W-1:0] drive_q;
	logic                      sat_q, clamped_q;

	assign dlim     = $signed({{(U_W-LIMIT_W-F){1'b0}}, drive_limit_q, {F{1'b0}}});
	assign dlim_int = $signed({{(DRIVE_W-LIMIT_W){1'b0}}, drive_limit_q});
	assign u_ceil   = (u_s5 + FMASK) >>> F;

	always_ff @(posedge clk) begin
		if (en_out) begin
			clamped_q <= clamped_s5;
			if (u_s5 > dlim) begin
				drive_q <= dlim_int;
				sat_q   <= 1'b1;
			end else if (u_s5 < -dlim) begin
				drive_q <= -dlim_int;
				sat_q   <= 1'b1;
			end else begin
				drive_q <= u_ceil[DRIVE_W-1:0];
				sat_q   <= 1'b0;
			end
		end
	end

	assign m_tdata = {{(M_TDATA_W-DRIVE_W-2){1'b0}}, clamped_q, sat_q, drive_q};

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	// a pinned sample leaves the error sum sitting on one of its bounds
	a_sum_pinned : assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && clamped_s2) |->
			(error_sum_q == lim[ESUM_W-1:0] ||
			 error_sum_q == lim_neg[ESUM_W-1:0]))
		else $error("error sum off its bound after clamp");

	// saturated drive sits exactly at the limit
	a_sat_at_limit : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && sat_q) |-> (drive_q == dlim_int || drive_q == -dlim_int))
		else $error("saturated drive not at limit");

	// rounded drive stays within the limit
	a_drive_in_range : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !sat_q) |-> (drive_q <= dlim_int && drive_q >= -dlim_int))
		else $error("unsaturated drive outside limit");

endmodule : pid_controller_clamped_integrator_unit

`default_nettype wire
